>>> sv/mdss_pkg.sv
package mdss_pkg;

  // Default capacity of the count store
  localparam int MAX_STRINGS_DEF = 32;
  // Results emitted per set at most
  localparam int EMIT_LIMIT      = 32;

  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 9;
  localparam int INDEX_W = 5;
  localparam int EMIT_W  = 6;
  localparam int NUM_SYMBOLS = 256;

  // Controller to datapath
  typedef struct packed {
    logic take;   // input item accepted this cycle
    logic emit;   // emit pass running
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;   // last result of the set is found this cycle
  } sts_t;

endpackage

>>> sv/mdss_ram.sv
module mdss_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/mdss_ctrl.sv
module mdss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               end_of_set,
  input  mdss_pkg::sts_t     sts,
  output logic               busy,
  output mdss_pkg::cmd_t     cmd
);

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_EMIT    = 1'b1;

  logic state_r;
  logic state_nxt;
  logic take;

  assign busy = (state_r == ST_EMIT);
  assign take = start && !busy;

  // Commands
  always_comb begin
    cmd.take = take;
    cmd.emit = (state_r == ST_EMIT);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (take && end_of_set) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.done) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/mdss_dp.sv
module mdss_dp #(
  parameter int MAX_STRINGS = mdss_pkg::MAX_STRINGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mdss_pkg::cmd_t                cmd,
  output mdss_pkg::sts_t                sts,
  input  logic [mdss_pkg::CHAR_W-1:0]   char_code,
  input  logic                          char_valid,
  input  logic                          end_of_string,
  input  logic                          end_of_set,
  output logic                          out_strobe,
  output logic [mdss_pkg::INDEX_W-1:0]  out_string_index,
  output logic [mdss_pkg::COUNT_W-1:0]  out_distinct_count,
  output logic                          out_strings_dropped,
  output logic                          out_last_result
);

  localparam int AW    = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam int LW    = $clog2(MAX_STRINGS + 1);
  localparam int CMP_W = (LW > mdss_pkg::EMIT_W) ? LW : mdss_pkg::EMIT_W;
  localparam int CW    = mdss_pkg::COUNT_W;
  localparam int EW    = mdss_pkg::EMIT_W;

  // Collect side state
  logic [mdss_pkg::NUM_SYMBOLS-1:0] seen_r, seen_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] loaded_r, loaded_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [LW-1:0] match_cnt_r, match_cnt_nxt;
  logic          ovf_r, ovf_nxt;

  // Emit side state
  logic [LW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_pos_r, rd_pos_nxt;
  logic [EW-1:0] emitted_r, emitted_nxt;

  // Output registers
  logic                         strobe_r, strobe_nxt;
  logic [mdss_pkg::INDEX_W-1:0] idx_r, idx_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         drop_r, drop_nxt;
  logic                         last_r, last_nxt;

  logic          new_char;
  logic [CW-1:0] closed_cnt;
  logic          close_str;
  logic          store_we;
  logic          rd_en;
  logic [CW-1:0] rd_data;
  logic [CMP_W-1:0] mc_ext;
  logic [CMP_W-1:0] lim_ext;
  logic [EW-1:0] target;
  logic          hit;
  logic          hit_last;

  // Count of the string including this item's character
  assign new_char   = cmd.take && char_valid && !seen_r[char_code];
  assign closed_cnt = cur_r + CW'(new_char);
  assign close_str  = cmd.take && (end_of_string || end_of_set);
  assign store_we   = close_str && (loaded_r < LW'(MAX_STRINGS));

  // Emit pass: read stored counts in order
  assign rd_en = cmd.emit && (rd_idx_r < loaded_r);

  mdss_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_STRINGS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (loaded_r[AW-1:0]),
    .wdata (closed_cnt),
    .re    (rd_en),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  // Number of results for this set, capped by the emit limit
  assign mc_ext  = CMP_W'(match_cnt_r);
  assign lim_ext = CMP_W'(mdss_pkg::EMIT_LIMIT);
  assign target  = (mc_ext > lim_ext) ? EW'(lim_ext) : EW'(mc_ext);

  assign hit      = rd_vld_r && (rd_data == best_r) && (emitted_r < target);
  assign hit_last = hit && ((emitted_r + EW'(1)) == target);

  assign sts.done = hit_last;

  // Next state
  always_comb begin
    seen_nxt      = seen_r;
    cur_nxt       = cur_r;
    loaded_nxt    = loaded_r;
    best_nxt      = best_r;
    match_cnt_nxt = match_cnt_r;
    ovf_nxt       = ovf_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = rd_en;
    rd_pos_nxt    = rd_idx_r[AW-1:0];
    emitted_nxt   = emitted_r;
    strobe_nxt    = hit;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    last_nxt      = last_r;

    // Mark the character seen
    if (new_char) begin
      seen_nxt[char_code] = 1'b1;
      cur_nxt = closed_cnt;
    end

    // Close the string: store count, track maximum and its multiplicity; when full, flag overflow
    if (close_str) begin
      seen_nxt = '0;
      cur_nxt  = '0;
      if (store_we) begin
        loaded_nxt = loaded_r + LW'(1);
        if (closed_cnt > best_r) begin
          best_nxt      = closed_cnt;
          match_cnt_nxt = LW'(1);
        end else if (closed_cnt == best_r) begin
          match_cnt_nxt = match_cnt_r + LW'(1);
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (rd_en) begin
      rd_idx_nxt = rd_idx_r + LW'(1);
    end

    // Result register
    if (hit) begin
      emitted_nxt = emitted_r + EW'(1);
      idx_nxt     = mdss_pkg::INDEX_W'(rd_pos_r);
      cnt_nxt     = rd_data;
      drop_nxt    = ovf_r;
      last_nxt    = hit_last;
    end

    // Set finished: back to the empty state
    if (hit_last) begin
      loaded_nxt    = '0;
      best_nxt      = '0;
      match_cnt_nxt = '0;
      ovf_nxt       = 1'b0;
      rd_idx_nxt    = '0;
      rd_vld_nxt    = 1'b0;
      emitted_nxt   = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      cur_r       <= '0;
      loaded_r    <= '0;
      best_r      <= '0;
      match_cnt_r <= '0;
      ovf_r       <= 1'b0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      emitted_r   <= '0;
      strobe_r    <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      cur_r       <= cur_nxt;
      loaded_r    <= loaded_nxt;
      best_r      <= best_nxt;
      match_cnt_r <= match_cnt_nxt;
      ovf_r       <= ovf_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      emitted_r   <= emitted_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_pos_r <= rd_pos_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    drop_r   <= drop_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe          = strobe_r;
  assign out_string_index    = idx_r;
  assign out_distinct_count  = cnt_r;
  assign out_strings_dropped = drop_r;
  assign out_last_result     = last_r;

endmodule

>>> sv/most_diverse_string_select_top.sv
// Most diverse string select.
// Input channel: characters arrive one item per clock; an item is taken on
// a rising edge with start high and busy low. Each item carries a byte
// (in_char_code, used when in_char_valid is high) and end marks for the
// string (in_end_of_string) and the whole set (in_end_of_set).
// While collecting, busy stays low and one item is taken every cycle with
// start high; the distinct-byte count of a string is stored when it closes.
// After the item with in_end_of_set, busy rises and the stored counts are
// read back one per cycle from the count memory. Every string whose count
// equals the set's maximum gives one result (at most EMIT_LIMIT per set),
// in string order, on the out_ ports for one cycle with out_strobe high;
// out_last_result marks the final one. The emit pass reads through the
// single read port of the count memory; it ends with the last result and
// busy falls in the cycle that result is shown.
// Strings closing once MAX_STRINGS are stored are dropped and flagged in
// out_strings_dropped. The receiver cannot stall: results are never held.
// Reset (rst_n low, synchronous) empties the set and clears out_strobe.
module most_diverse_string_select_top #(
  parameter int MAX_STRINGS = mdss_pkg::MAX_STRINGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mdss_pkg::CHAR_W-1:0]   in_char_code,
  input  logic                          in_char_valid,
  input  logic                          in_end_of_string,
  input  logic                          in_end_of_set,
  output logic                          out_strobe,
  output logic [mdss_pkg::INDEX_W-1:0]  out_string_index,
  output logic [mdss_pkg::COUNT_W-1:0]  out_distinct_count,
  output logic                          out_strings_dropped,
  output logic                          out_last_result
);

  mdss_pkg::cmd_t cmd;
  mdss_pkg::sts_t sts;

  // Sequencer
  mdss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .end_of_set (in_end_of_set),
    .sts        (sts),
    .busy       (busy),
    .cmd        (cmd)
  );

  // Counting, storage and emit path
  mdss_dp #(
    .MAX_STRINGS (MAX_STRINGS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .char_code           (in_char_code),
    .char_valid          (in_char_valid),
    .end_of_string       (in_end_of_string),
    .end_of_set          (in_end_of_set),
    .out_strobe          (out_strobe),
    .out_string_index    (out_string_index),
    .out_distinct_count  (out_distinct_count),
    .out_strings_dropped (out_strings_dropped),
    .out_last_result     (out_last_result)
  );

endmodule

>>> verif/mdss_diversity_monitor.sv
`timescale 1ns / 1ps
// Watches both channels of the block, keeps its own count of distinct bytes
// per string and predicts which strings tie for the maximum at set close.
module mdss_diversity_monitor #(
  parameter int MAX_STRINGS = mdss_pkg::MAX_STRINGS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [mdss_pkg::CHAR_W-1:0]  in_char_code,
  input  logic                         in_char_valid,
  input  logic                         in_end_of_string,
  input  logic                         in_end_of_set,
  input  logic                         out_strobe,
  input  logic [mdss_pkg::INDEX_W-1:0] out_string_index,
  input  logic [mdss_pkg::COUNT_W-1:0] out_distinct_count,
  input  logic                         out_strings_dropped,
  input  logic                         out_last_result,
  output int                           fail_count,
  output int                           pending,
  output int                           checked
);

  typedef struct packed {
    logic [mdss_pkg::INDEX_W-1:0] idx;
    logic [mdss_pkg::COUNT_W-1:0] cnt;
    logic                         dropped;
    logic                         last;
  } best_hit_t;

  // Strings at the maximum, oldest first
  best_hit_t best_hits_due[$];

  // Predicted block state
  bit                           seen_byte [mdss_pkg::NUM_SYMBOLS];
  logic [mdss_pkg::COUNT_W-1:0] run_distinct;
  logic [mdss_pkg::COUNT_W-1:0] stored_counts [MAX_STRINGS];
  int                           stored_n;
  logic [mdss_pkg::COUNT_W-1:0] top_count;
  bit                           dropped_flag;

  int errors = 0;
  int n_checked = 0;

  task automatic clear_set();
    seen_byte    = '{default: 1'b0};
    run_distinct = '0;
    stored_n     = 0;
    top_count    = '0;
    dropped_flag = 1'b0;
  endtask

  // One accepted item: count its byte, close the string, emit on set close
  task automatic predict_item(input logic [mdss_pkg::CHAR_W-1:0] code, input logic valid,
                              input logic eos, input logic eset);
    best_hit_t batch[$];
    best_hit_t h;
    if (valid && !seen_byte[code]) begin
      seen_byte[code] = 1'b1;
      if (run_distinct < mdss_pkg::NUM_SYMBOLS) run_distinct = run_distinct + 1'b1;
    end
    if (eos || eset) begin
      if (stored_n < MAX_STRINGS) begin
        stored_counts[stored_n] = run_distinct;
        if (run_distinct > top_count) top_count = run_distinct;
        stored_n++;
      end else begin
        dropped_flag = 1'b1;
      end
      seen_byte    = '{default: 1'b0};
      run_distinct = '0;
    end
    if (eset) begin
      for (int i = 0; i < stored_n; i++) begin
        if (stored_counts[i] == top_count && batch.size() < mdss_pkg::EMIT_LIMIT) begin
          h.idx     = mdss_pkg::INDEX_W'(i);
          h.cnt     = stored_counts[i];
          h.dropped = dropped_flag;
          h.last    = 1'b0;
          batch     = {batch, h};
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      best_hits_due = {best_hits_due, batch};
      clear_set();
    end
  endtask

  always @(posedge clk) begin : watch
    best_hit_t want;
    if (!rst_n) begin
      clear_set();
      best_hits_due.delete();
    end else begin
      // results first: the last one of a set may share an edge with a new item
      if (out_strobe === 1'b1) begin
        if (best_hits_due.size() == 0) begin
          $display("%0t: unexpected result index %0d count %0d", $time,
                   out_string_index, out_distinct_count);
          errors++;
        end else begin
          want = best_hits_due.pop_front();
          n_checked++;
          if (out_string_index !== want.idx) begin
            $display("%0t: string_index expected %0d, got %0d", $time,
                     want.idx, out_string_index);
            errors++;
          end
          if (out_distinct_count !== want.cnt) begin
            $display("%0t: distinct_count expected %0d, got %0d", $time,
                     want.cnt, out_distinct_count);
            errors++;
          end
          if (out_strings_dropped !== want.dropped) begin
            $display("%0t: strings_dropped expected %0b, got %0b", $time,
                     want.dropped, out_strings_dropped);
            errors++;
          end
          if (out_last_result !== want.last) begin
            $display("%0t: last_result expected %0b, got %0b", $time,
                     want.last, out_last_result);
            errors++;
          end
        end
      end else if (out_strobe !== 1'b0) begin
        $display("%0t: out_strobe expected 0 or 1, got %b", $time, out_strobe);
        errors++;
      end
      if (start && busy === 1'b0)
        predict_item(in_char_code, in_char_valid, in_end_of_string, in_end_of_set);
    end
    fail_count <= errors;
    pending    <= best_hits_due.size();
    checked    <= n_checked;
  end

endmodule

>>> verif/tb_most_diverse_string_select_top.sv
`timescale 1ns / 1ps
module tb_most_diverse_string_select_top;

  localparam int MAX_STRINGS = mdss_pkg::MAX_STRINGS_DEF;
  localparam int CHAR_W      = mdss_pkg::CHAR_W;
  localparam int NUM_SYMBOLS = mdss_pkg::NUM_SYMBOLS;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [CHAR_W-1:0]            in_char_code;
  logic                         in_char_valid;
  logic                         in_end_of_string;
  logic                         in_end_of_set;
  logic                         out_strobe;
  logic [mdss_pkg::INDEX_W-1:0] out_string_index;
  logic [mdss_pkg::COUNT_W-1:0] out_distinct_count;
  logic                         out_strings_dropped;
  logic                         out_last_result;

  int mon_fails;
  int mon_pending;
  int mon_checked;

  int items_sent;
  int sets_sent;
  int quiet_from;
  int quiet_to;

  most_diverse_string_select_top #(.MAX_STRINGS(MAX_STRINGS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_char_code        (in_char_code),
    .in_char_valid       (in_char_valid),
    .in_end_of_string    (in_end_of_string),
    .in_end_of_set       (in_end_of_set),
    .out_strobe          (out_strobe),
    .out_string_index    (out_string_index),
    .out_distinct_count  (out_distinct_count),
    .out_strings_dropped (out_strings_dropped),
    .out_last_result     (out_last_result)
  );

  mdss_diversity_monitor #(.MAX_STRINGS(MAX_STRINGS)) u_monitor (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_char_code        (in_char_code),
    .in_char_valid       (in_char_valid),
    .in_end_of_string    (in_end_of_string),
    .in_end_of_set       (in_end_of_set),
    .out_strobe          (out_strobe),
    .out_string_index    (out_string_index),
    .out_distinct_count  (out_distinct_count),
    .out_strings_dropped (out_strings_dropped),
    .out_last_result     (out_last_result),
    .fail_count          (mon_fails),
    .pending             (mon_pending),
    .checked             (mon_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Drive one item and hold it until the block takes it
  task automatic send_item(input logic [CHAR_W-1:0] code, input logic valid,
                           input logic eos, input logic eset);
    if (!(items_sent >= quiet_from && items_sent < quiet_to) &&
        $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start            <= 1'b1;
    in_char_code     <= code;
    in_char_valid    <= valid;
    in_end_of_string <= eos;
    in_end_of_set    <= eset;
    do @(posedge clk); while (busy !== 1'b0);
    if (valid || eos || eset) items_sent++;
  endtask

  // One string; small alphabets give repeats and ties between strings
  task automatic send_string(input int len, input bit small_alpha, input bit is_last);
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] code;
    bit mark_on_char;
    bit with_eos;
    base         = CHAR_W'($urandom);
    mark_on_char = (len > 0) && ($urandom_range(0, 99) < 60);
    with_eos     = is_last ? 1'($urandom_range(0, 1)) : 1'b1;
    for (int k = 0; k < len; k++) begin
      // stray items with no character and no mark
      if ($urandom_range(0, 99) < 8) send_item(CHAR_W'($urandom), 1'b0, 1'b0, 1'b0);
      code = small_alpha ? base + CHAR_W'($urandom_range(0, 2)) : CHAR_W'($urandom);
      if (k == len - 1 && mark_on_char) send_item(code, 1'b1, with_eos, is_last);
      else send_item(code, 1'b1, 1'b0, 1'b0);
    end
    if (!mark_on_char) send_item(CHAR_W'($urandom), 1'b0, with_eos, is_last);
  endtask

  task automatic send_set(input int n_str);
    bit small_alpha;
    int len;
    small_alpha = 1'($urandom_range(0, 1));
    for (int s = 0; s < n_str; s++) begin
      len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 6) : $urandom_range(7, 20);
      send_string(len, small_alpha, s == n_str - 1);
    end
    sets_sent++;
  endtask

  initial begin : stimulus
    logic [CHAR_W-1:0] perm [NUM_SYMBOLS];
    logic [CHAR_W-1:0] tmp;
    int j;
    int r;
    int rand_end;
    int guard;

    items_sent = 0;
    sets_sent  = 0;
    quiet_from = 0;
    quiet_to   = 0;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_char_code     <= '0;
    in_char_valid    <= 1'b0;
    in_end_of_string <= 1'b0;
    in_end_of_set    <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte extremes, repeats, ignored item, empty strings, tie for the max
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'h07, 1'b0, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1, 1'b0);
    send_item(8'h09, 1'b1, 1'b0, 1'b0);
    send_item(8'hC8, 1'b1, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1, 1'b1);
    // set closed by the end-of-set mark alone, on a character
    send_item(8'h05, 1'b1, 1'b0, 1'b1);
    // set of a single empty string
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    // both marks on one character
    send_item(8'h80, 1'b1, 1'b1, 1'b1);
    // a later string beats the earlier maximum
    send_item(8'h01, 1'b1, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0, 1'b0);
    send_item(8'h03, 1'b1, 1'b0, 1'b0);
    send_item(8'h04, 1'b1, 1'b1, 1'b1);
    sets_sent += 5;

    // every byte value in one string, with a few repeats: count 256
    foreach (perm[k]) perm[k] = CHAR_W'(k);
    for (int k = NUM_SYMBOLS - 1; k > 0; k--) begin
      j       = $urandom_range(0, k);
      tmp     = perm[k];
      perm[k] = perm[j];
      perm[j] = tmp;
    end
    for (int k = 0; k < NUM_SYMBOLS; k++) begin
      if (k > 0 && $urandom_range(0, 99) < 5) send_item(perm[k-1], 1'b1, 1'b0, 1'b0);
      send_item(perm[k], 1'b1, k == NUM_SYMBOLS - 1, 1'b0);
    end
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    sets_sent++;

    // capacity overrun where every stored string ties: a full emit pass
    for (int s = 0; s < MAX_STRINGS + 4; s++)
      send_string(1, 1'b1, s == MAX_STRINGS + 3);
    sets_sent++;

    // random sets up to the item budget, with one stretch free of input gaps
    rand_end   = 450;
    quiet_from = items_sent + 10;
    quiet_to   = items_sent + 80;
    while (items_sent < rand_end) begin
      r = $urandom_range(0, 99);
      if (r < 65)      send_set($urandom_range(1, 6));
      else if (r < 80) send_set($urandom_range(7, MAX_STRINGS - 1));
      else             send_set($urandom_range(MAX_STRINGS, MAX_STRINGS + 8));
    end
    start <= 1'b0;

    // drain, then allow for a full emit pass
    guard = 0;
    while (mon_pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (MAX_STRINGS + 4) @(posedge clk);

    $display("Run sent %0d items in %0d sets and checked %0d results,", items_sent,
             sets_sent, mon_checked);
    $display("including empty and full-alphabet strings and capacity overruns.");
    if (mon_fails == 0 && mon_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
sv/mdss_pkg.sv
sv/mdss_ram.sv
sv/mdss_ctrl.sv
sv/mdss_dp.sv
sv/most_diverse_string_select_top.sv
verif/mdss_diversity_monitor.sv
verif/tb_most_diverse_string_select_top.sv
